// ===== rtl/lwis_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear wind input spectrum package
// Shared constants, command and register codes, tables and channel types.
// ----------------------------------------------------------------------------
package lwis_pkg;

  localparam int MAX_DIRS  = 64;
  localparam int MAX_FREQS = 64;
  localparam int DIR_AW    = $clog2(MAX_DIRS);
  localparam int FRQ_AW    = $clog2(MAX_FREQS);
  localparam int CNT_W     = 7;

  localparam int DIV_NW = 64;
  localparam int DIV_DW = 24;
  localparam int ACC_W  = 104;

  localparam logic [16:0] FF_MAX = 17'h1FFFF;
  localparam logic [47:0] MAX48  = 48'hFFFF_FFFF_FFFF;

  localparam logic [39:0] LIN_GAIN_RST = 40'd207800;
  localparam logic [15:0] PM_RST       = 16'd4096;
  localparam logic [15:0] CUT_RST      = 16'd8192;
  localparam logic [15:0] GRAV_RST     = 16'd20091;
  localparam logic [6:0]  DIRS_RST     = 7'd24;
  localparam logic [6:0]  FREQS_RST    = 7'd25;

  localparam logic signed [19:0] CORDIC_X0 = 20'sd39797;
  localparam logic [3:0]         CORDIC_LAST = 4'd13;

  typedef enum logic [1:0] {
    CMD_LOAD_DIR  = 2'd0,
    CMD_LOAD_FRQ  = 2'd1,
    CMD_SET_POINT = 2'd2,
    CMD_EMIT      = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_LIN_GAIN = 3'd0,
    CFG_PM       = 3'd1,
    CFG_CUTOFF   = 3'd2,
    CFG_GRAVITY  = 3'd3,
    CFG_DIRS     = 3'd4,
    CFG_FREQS    = 3'd5
  } cfg_e;

  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_TRIG = 20'h00002,
    S_DRD  = 20'h00004,
    S_DPRD = 20'h00008,
    S_DSUM = 20'h00010,
    S_DSQ1 = 20'h00020,
    S_DSQ2 = 20'h00040,
    S_GAIN = 20'h00080,
    S_FF   = 20'h00100,
    S_FFW  = 20'h00200,
    S_FF2  = 20'h00400,
    S_ERD  = 20'h00800,
    S_ECHK = 20'h01000,
    S_EQW  = 20'h02000,
    S_EXP  = 20'h04000,
    S_ERW  = 20'h08000,
    S_ET   = 20'h10000,
    S_ORD  = 20'h20000,
    S_OPRD = 20'h40000,
    S_OOUT = 20'h80000
  } state_e;

  typedef struct packed {
    logic signed [15:0] dcos;
    logic signed [15:0] dsin;
    logic [15:0]        dirf;
  } dir_word_t;

  typedef struct packed {
    logic [15:0] freq;
    logic [23:0] wnum;
  } frq_word_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

  function automatic logic [13:0] atan_f(input logic [3:0] i);
    logic [13:0] r;
    unique case (i)
      4'd0:    r = 14'd8192;
      4'd1:    r = 14'd4836;
      4'd2:    r = 14'd2555;
      4'd3:    r = 14'd1297;
      4'd4:    r = 14'd651;
      4'd5:    r = 14'd326;
      4'd6:    r = 14'd163;
      4'd7:    r = 14'd81;
      4'd8:    r = 14'd41;
      4'd9:    r = 14'd20;
      4'd10:   r = 14'd10;
      4'd11:   r = 14'd5;
      4'd12:   r = 14'd3;
      4'd13:   r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

  function automatic logic [32:0] e_int_f(input logic [4:0] n);
    logic [32:0] r;
    unique case (n)
      5'd0:    r = 33'd4294967296;
      5'd1:    r = 33'd1580030169;
      5'd2:    r = 33'd581260615;
      5'd3:    r = 33'd213833830;
      5'd4:    r = 33'd78665070;
      5'd5:    r = 33'd28939262;
      5'd6:    r = 33'd10646160;
      5'd7:    r = 33'd3916503;
      5'd8:    r = 33'd1440801;
      5'd9:    r = 33'd530041;
      5'd10:   r = 33'd194991;
      5'd11:   r = 33'd71733;
      5'd12:   r = 33'd26389;
      5'd13:   r = 33'd9708;
      5'd14:   r = 33'd3571;
      5'd15:   r = 33'd1314;
      default: r = 33'd483;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] e_frac_f(input logic [4:0] j);
    logic [16:0] r;
    unique case (j)
      5'd0:    r = 17'd65536;
      5'd1:    r = 17'd61565;
      5'd2:    r = 17'd57835;
      5'd3:    r = 17'd54331;
      5'd4:    r = 17'd51040;
      5'd5:    r = 17'd47947;
      5'd6:    r = 17'd45042;
      5'd7:    r = 17'd42313;
      5'd8:    r = 17'd39750;
      5'd9:    r = 17'd37341;
      5'd10:   r = 17'd35079;
      5'd11:   r = 17'd32954;
      5'd12:   r = 17'd30957;
      5'd13:   r = 17'd29081;
      5'd14:   r = 17'd27319;
      5'd15:   r = 17'd25664;
      default: r = 17'd24109;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/lwis_div.sv =====
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lwis_div import lwis_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW-1:0] dv_q;
  logic [DIV_NW-1:0] quo_q;
  logic [6:0]        cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   rem_sub;
  logic              ge;

  assign rem_sh  = {rem_q, quo_q[DIV_NW-1]};
  assign ge      = rem_sh >= {1'b0, dv_q};
  assign rem_sub = rem_sh - {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dv_q   <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q  <= '0;
        dv_q   <= req_i.divisor;
        quo_q  <= req_i.dividend;
        cnt_q  <= 7'(DIV_NW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
        quo_q <= {quo_q[DIV_NW-2:0], ge};
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== rtl/linear_wind_input_spectrum.sv =====
// ----------------------------------------------------------------------------
// Linear wind input spectrum
// Filtered linear wind input source term over stored direction and
// frequency tables.
// ----------------------------------------------------------------------------
// Load items go straight into the tables, leaving the sequencer idle. A
// set-point item runs 14 CORDIC steps, then a read, the products, the clamped
// sum and the squaring for each of all 64 direction-memory entries, nine
// shared-multiplier steps for the gain and a 64-step divide for the filter
// frequency. An emit item runs two 64-step divides through the shared divider,
// exponent and gain steps on the shared multiplier, then one direction-memory
// read and a pair of multiplies per result. The input stalls for the whole
// item; a result waits in the output register while the next one is formed.
module linear_wind_input_spectrum import lwis_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         in_command_i,
  input  logic [5:0]         in_bin_index_i,
  input  logic signed [15:0] in_dir_cos_i,
  input  logic signed [15:0] in_dir_sin_i,
  input  logic [15:0]        in_rad_freq_i,
  input  logic [23:0]        in_wavenumber_i,
  input  logic [15:0]        in_friction_velocity_i,
  input  logic [15:0]        in_wind_angle_i,
  input  logic [15:0]        in_cutoff_freq_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [47:0]        out_source_value_o,
  output logic [5:0]         out_dir_index_o,
  output logic [5:0]         out_freq_index_o,
  output logic               out_last_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [39:0]        cfg_data_i
);

  dir_word_t dir_mem [MAX_DIRS];
  frq_word_t frq_mem [MAX_FREQS];
  dir_word_t dir_rd_q;
  frq_word_t frq_rd_q;

  state_e state_q;
  logic [3:0] stp_q;

  logic [39:0] lg_q;
  logic [15:0] pm_q, cf_q, grav_q;
  logic [CNT_W-1:0] nd_q, nf_q, nd_c, nf_c;

  logic [47:0] gain_q;
  logic [16:0] ffilt_q;
  logic        calm_q;

  logic [15:0] u_q, fh_q;
  logic [DIR_AW-1:0] i_q;
  logic [FRQ_AW-1:0] idx_q;

  logic signed [19:0] x_q, y_q, cu, su;
  logic signed [17:0] z_q, zs, z_fold;
  logic [3:0]  it_q;
  logic        neg_q, neg_fold;

  logic signed [35:0] pc_q, ps_q;
  logic signed [36:0] psum;
  logic [14:0] pq_q, p2_q;
  logic [29:0] pq_sq;
  logic [29:0] p2_sq;

  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_q;
  logic [63:0] u4_q;
  logic [ACC_W-1:0] acc_q;
  logic [16:0] ff1_q, ff2, top;
  logic [15:0] smax_min;

  logic [17:0] q_q;
  logic [20:0] xc_q;
  logic [16:0] ef_q, ediff;
  logic [32:0] w_q;
  logic [63:0] row_q, t_q;
  logic [23:0] k_q;
  logic        zero_row;

  logic [47:0] plo_q, phi_q;
  logic [79:0] prod;
  logic [47:0] vsat;
  logic        last_dir;
  logic        ov_q;
  logic        out_load;

  logic        in_acc;
  logic [FRQ_AW-1:0] frq_ra;
  logic [DIR_AW-1:0] dir_wa;
  logic        dir_we_cs, dir_we_f, frq_we;
  logic [15:0] dirf_w;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign nd_c = (nd_q == '0) ? CNT_W'(1) : (nd_q > CNT_W'(MAX_DIRS)) ? CNT_W'(MAX_DIRS) : nd_q;
  assign nf_c = (nf_q == '0) ? CNT_W'(1) : (nf_q > CNT_W'(MAX_FREQS)) ? CNT_W'(MAX_FREQS) : nf_q;

  // direction memory
  assign dir_we_cs = in_acc && (in_command_i == CMD_LOAD_DIR);
  assign dir_we_f  = (state_q == S_DSQ2);
  assign dir_wa    = (state_q == S_IDLE) ? in_bin_index_i : i_q;
  assign p2_sq     = 30'(p2_q) * 30'(p2_q);
  assign dirf_w    = p2_sq[28:13];

  always_ff @(posedge clk_i) begin
    if (dir_we_cs) begin
      dir_mem[dir_wa].dcos <= in_dir_cos_i;
      dir_mem[dir_wa].dsin <= in_dir_sin_i;
    end
    if (dir_we_f) begin
      dir_mem[dir_wa].dirf <= dirf_w;
    end
    dir_rd_q <= dir_mem[i_q];
  end

  // frequency memory
  assign frq_we = in_acc && (in_command_i == CMD_LOAD_FRQ);
  assign frq_ra = (state_q == S_ERD || state_q == S_ECHK) ? idx_q : FRQ_AW'(nf_c - CNT_W'(1));

  always_ff @(posedge clk_i) begin
    if (frq_we) begin
      frq_mem[in_bin_index_i] <= {in_rad_freq_i, in_wavenumber_i};
    end
    frq_rd_q <= frq_mem[frq_ra];
  end

  // wind angle fold
  always_comb begin
    zs       = 18'(signed'(in_wind_angle_i));
    z_fold   = zs;
    neg_fold = 1'b0;
    if (zs > 18'sd16384) begin
      z_fold   = zs - 18'sd32768;
      neg_fold = 1'b1;
    end else if (zs < -18'sd16384) begin
      z_fold   = zs + 18'sd32768;
      neg_fold = 1'b1;
    end
  end

  assign cu = neg_q ? -x_q : x_q;
  assign su = neg_q ? -y_q : y_q;

  assign psum  = 37'(pc_q) + 37'(ps_q);
  assign pq_sq = 30'(pq_q) * 30'(pq_q);

  // shared multiplier
  assign smax_min = (frq_rd_q.freq < fh_q) ? frq_rd_q.freq : fh_q;
  assign ediff    = e_frac_f({1'b0, xc_q[15:12]}) - e_frac_f({1'b0, xc_q[15:12]} + 5'd1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_GAIN: begin
        case (stp_q)
          4'd0: begin mul_a = 33'(u_q); mul_b = 33'(u_q); end
          4'd1: begin mul_a = 33'(mul_q[31:0]); mul_b = 33'(mul_q[31:0]); end
          4'd3: begin mul_a = 33'(lg_q[31:0]); mul_b = 33'(u4_q[31:0]); end
          4'd4: begin mul_a = 33'(lg_q[31:0]); mul_b = 33'(u4_q[63:32]); end
          4'd5: begin mul_a = 33'(lg_q[39:32]); mul_b = 33'(u4_q[31:0]); end
          4'd6: begin mul_a = 33'(lg_q[39:32]); mul_b = 33'(u4_q[63:32]); end
          default: ;
        endcase
      end
      S_FF: begin
        mul_a = 33'(pm_q);
        mul_b = 33'(grav_q);
      end
      S_FF2: begin
        mul_a = 33'(cf_q);
        mul_b = 33'(smax_min);
      end
      S_EXP: begin
        case (stp_q)
          4'd0: begin mul_a = 33'(q_q); mul_b = 33'(q_q); end
          4'd1: begin mul_a = mul_q[48:16]; mul_b = mul_q[48:16]; end
          4'd3: begin mul_a = 33'(ediff); mul_b = 33'(xc_q[11:0]); end
          4'd5: begin mul_a = e_int_f(xc_q[20:16]); mul_b = 33'(ef_q); end
          default: ;
        endcase
      end
      S_ET: begin
        mul_a = (stp_q == 4'd0) ? 33'(row_q[31:0]) : 33'(row_q[63:32]);
        mul_b = w_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= 66'(mul_a) * 66'(mul_b);
  end

  // divider requests
  assign zero_row = calm_q || (ffilt_q == '0) || ({frq_rd_q.freq, 1'b0} < ffilt_q);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_q)
      S_FF: begin
        div_req.start    = (stp_q == 4'd1) && (u_q != '0);
        div_req.dividend = DIV_NW'(mul_q[31:0]);
        div_req.divisor  = DIV_DW'({u_q, 4'b0}) - DIV_DW'({u_q, 1'b0});
      end
      S_ECHK: begin
        div_req.start    = !zero_row;
        div_req.dividend = DIV_NW'({ffilt_q, 16'b0});
        div_req.divisor  = DIV_DW'(frq_rd_q.freq);
      end
      S_EXP: begin
        div_req.start    = (stp_q == 4'd6);
        div_req.dividend = {gain_q, 16'b0};
        div_req.divisor  = k_q;
      end
      default: ;
    endcase
  end

  lwis_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign ff2 = (mul_q[31:29] != '0) ? FF_MAX : mul_q[28:12];
  assign top = (ff1_q > ff2) ? ff1_q : ff2;

  assign prod     = {phi_q, 32'b0} + 80'(plo_q);
  assign vsat     = (prod[79:63] != '0) ? MAX48 : prod[62:15];
  assign last_dir = (i_q == DIR_AW'(nd_c - CNT_W'(1)));
  assign out_load = (state_q == S_OOUT) && (!ov_q || !out_stall_i);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stp_q   <= '0;
      lg_q    <= LIN_GAIN_RST;
      pm_q    <= PM_RST;
      cf_q    <= CUT_RST;
      grav_q  <= GRAV_RST;
      nd_q    <= DIRS_RST;
      nf_q    <= FREQS_RST;
      gain_q  <= '0;
      ffilt_q <= '0;
      calm_q  <= 1'b1;
      ov_q    <= 1'b0;
      u_q     <= '0;
      fh_q    <= '0;
      i_q     <= '0;
      idx_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      it_q    <= '0;
      neg_q   <= 1'b0;
      pc_q    <= '0;
      ps_q    <= '0;
      pq_q    <= '0;
      p2_q    <= '0;
      u4_q    <= '0;
      acc_q   <= '0;
      ff1_q   <= '0;
      q_q     <= '0;
      xc_q    <= '0;
      ef_q    <= '0;
      w_q     <= '0;
      row_q   <= '0;
      t_q     <= '0;
      k_q     <= '0;
      plo_q   <= '0;
      phi_q   <= '0;
      out_source_value_o <= '0;
      out_dir_index_o    <= '0;
      out_freq_index_o   <= '0;
      out_last_o         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_LIN_GAIN: lg_q   <= cfg_data_i;
          CFG_PM:       pm_q   <= cfg_data_i[15:0];
          CFG_CUTOFF:   cf_q   <= cfg_data_i[15:0];
          CFG_GRAVITY:  grav_q <= cfg_data_i[15:0];
          CFG_DIRS:     nd_q   <= cfg_data_i[CNT_W-1:0];
          CFG_FREQS:    nf_q   <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        ov_q <= 1'b1;
      end else if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            idx_q <= in_bin_index_i;
            unique case (cmd_e'(in_command_i))
              CMD_SET_POINT: begin
                u_q     <= in_friction_velocity_i;
                fh_q    <= in_cutoff_freq_i;
                x_q     <= CORDIC_X0;
                y_q     <= '0;
                z_q     <= z_fold;
                neg_q   <= neg_fold;
                it_q    <= '0;
                state_q <= S_TRIG;
              end
              CMD_EMIT: begin
                if (CNT_W'(in_bin_index_i) < nf_c) begin
                  state_q <= S_ERD;
                end
              end
              CMD_LOAD_DIR, CMD_LOAD_FRQ: ;
            endcase
          end
        end
        S_TRIG: begin
          if (z_q >= 0) begin
            x_q <= x_q - (y_q >>> it_q);
            y_q <= y_q + (x_q >>> it_q);
            z_q <= z_q - signed'({4'b0, atan_f(it_q)});
          end else begin
            x_q <= x_q + (y_q >>> it_q);
            y_q <= y_q - (x_q >>> it_q);
            z_q <= z_q + signed'({4'b0, atan_f(it_q)});
          end
          it_q <= it_q + 4'd1;
          if (it_q == CORDIC_LAST) begin
            i_q     <= '0;
            state_q <= S_DRD;
          end
        end
        S_DRD: state_q <= S_DPRD;
        S_DPRD: begin
          pc_q    <= dir_rd_q.dcos * cu;
          ps_q    <= dir_rd_q.dsin * su;
          state_q <= S_DSUM;
        end
        S_DSUM: begin
          if (psum <= 0) begin
            pq_q <= '0;
          end else if (psum[36:16] > 21'd16384) begin
            pq_q <= 15'd16384;
          end else begin
            pq_q <= psum[30:16];
          end
          state_q <= S_DSQ1;
        end
        S_DSQ1: begin
          p2_q    <= pq_sq[28:14];
          state_q <= S_DSQ2;
        end
        S_DSQ2: begin
          if (i_q == DIR_AW'(MAX_DIRS - 1)) begin
            stp_q   <= '0;
            state_q <= S_GAIN;
          end else begin
            i_q     <= i_q + DIR_AW'(1);
            state_q <= S_DRD;
          end
        end
        S_GAIN: begin
          stp_q <= stp_q + 4'd1;
          case (stp_q)
            4'd2: begin
              u4_q  <= mul_q[63:0];
              acc_q <= '0;
            end
            4'd4: acc_q <= acc_q + ACC_W'(mul_q);
            4'd5: acc_q <= acc_q + (ACC_W'(mul_q) << 32);
            4'd6: acc_q <= acc_q + (ACC_W'(mul_q) << 32);
            4'd7: acc_q <= acc_q + (ACC_W'(mul_q) << 64);
            4'd8: begin
              gain_q  <= (acc_q[103:100] != '0) ? MAX48 : acc_q[99:52];
              stp_q   <= '0;
              state_q <= S_FF;
            end
            default: ;
          endcase
        end
        S_FF: begin
          stp_q <= 4'd1;
          if (stp_q == 4'd1) begin
            stp_q <= '0;
            if (u_q == '0) begin
              ff1_q   <= FF_MAX;
              state_q <= S_FF2;
            end else begin
              state_q <= S_FFW;
            end
          end
        end
        S_FFW: begin
          if (div_rsp.done) begin
            ff1_q   <= (div_rsp.quotient[63:17] != '0) ? FF_MAX : div_rsp.quotient[16:0];
            stp_q   <= '0;
            state_q <= S_FF2;
          end
        end
        S_FF2: begin
          stp_q <= 4'd1;
          if (stp_q == 4'd1) begin
            ffilt_q <= (top > {frq_rd_q.freq, 1'b0}) ? {frq_rd_q.freq, 1'b0} : top;
            calm_q  <= (u_q == '0);
            stp_q   <= '0;
            state_q <= S_IDLE;
          end
        end
        S_ERD: state_q <= S_ECHK;
        S_ECHK: begin
          k_q <= (frq_rd_q.wnum == '0) ? 24'd1 : frq_rd_q.wnum;
          if (zero_row) begin
            t_q     <= '0;
            i_q     <= '0;
            state_q <= S_ORD;
          end else begin
            state_q <= S_EQW;
          end
        end
        S_EQW: begin
          if (div_rsp.done) begin
            q_q     <= div_rsp.quotient[17:0];
            stp_q   <= '0;
            state_q <= S_EXP;
          end
        end
        S_EXP: begin
          stp_q <= stp_q + 4'd1;
          case (stp_q)
            4'd2: xc_q <= (mul_q[65:16] > 50'h10_0000) ? 21'h10_0000 : mul_q[36:16];
            4'd4: ef_q <= e_frac_f({1'b0, xc_q[15:12]}) - 17'(mul_q[23:12]);
            4'd6: begin
              w_q     <= xc_q[20] ? e_int_f(xc_q[20:16]) : mul_q[48:16];
              stp_q   <= '0;
              state_q <= S_ERW;
            end
            default: ;
          endcase
        end
        S_ERW: begin
          if (div_rsp.done) begin
            row_q   <= div_rsp.quotient;
            stp_q   <= '0;
            state_q <= S_ET;
          end
        end
        S_ET: begin
          stp_q <= stp_q + 4'd1;
          case (stp_q)
            4'd1: acc_q <= ACC_W'(mul_q);
            4'd2: acc_q <= acc_q + (ACC_W'(mul_q) << 32);
            4'd3: begin
              t_q     <= (acc_q[96:88] != '0) ? '1 : acc_q[87:24];
              i_q     <= '0;
              stp_q   <= '0;
              state_q <= S_ORD;
            end
            default: ;
          endcase
        end
        S_ORD: state_q <= S_OPRD;
        S_OPRD: begin
          plo_q   <= 48'(t_q[31:0]) * 48'(dir_rd_q.dirf);
          phi_q   <= 48'(t_q[63:32]) * 48'(dir_rd_q.dirf);
          state_q <= S_OOUT;
        end
        S_OOUT: begin
          if (out_load) begin
            out_source_value_o <= vsat;
            out_dir_index_o    <= i_q;
            out_freq_index_o   <= idx_q;
            out_last_o         <= last_dir;
            if (last_dir) begin
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_q + DIR_AW'(1);
              state_q <= S_ORD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = ov_q;

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_FFW || state_q == S_EQW || state_q == S_ERW))
    else $error("quotient arrived outside a wait state");

  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OOUT))
    else $error("result appeared outside the emit loop");

  a_last_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_last_o |-> out_dir_index_o == DIR_AW'(nd_c - CNT_W'(1)))
    else $error("last flag on wrong direction");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Linear wind input spectrum testbench
// Loads direction and frequency tables, walks a directed list of set-point,
// emit and load items, then random traffic over several register settings.
// Every result is checked against a bit-true predictor of the source term or
// a pinned value, with random gaps on the input and random stalls on output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb import lwis_pkg::*; ();

  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam int         SETTLE       = 800;

  typedef struct {
    cmd_e               cmd;
    logic [5:0]         idx;
    logic signed [15:0] dc;
    logic signed [15:0] ds;
    logic [15:0]        fr;
    logic [23:0]        wn;
    logic [15:0]        u;
    logic [15:0]        ang;
    logic [15:0]        fc;
    bit                 pinned;
    logic [47:0]        pin_val;
  } item_t;

  typedef struct {
    logic [47:0] val;
    logic [5:0]  dir;
    logic [5:0]  frq;
    logic        is_last;
  } source_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         in_command_i = '0;
  logic [5:0]         in_bin_index_i = '0;
  logic signed [15:0] in_dir_cos_i = '0;
  logic signed [15:0] in_dir_sin_i = '0;
  logic [15:0]        in_rad_freq_i = '0;
  logic [23:0]        in_wavenumber_i = '0;
  logic [15:0]        in_friction_velocity_i = '0;
  logic [15:0]        in_wind_angle_i = '0;
  logic [15:0]        in_cutoff_freq_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [47:0]        out_source_value_o;
  logic [5:0]         out_dir_index_o;
  logic [5:0]         out_freq_index_o;
  logic               out_last_o;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_index_i = '0;
  logic [39:0]        cfg_data_i = '0;

  int ang_step [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
  longint unsigned exp_whole [17] = '{
    64'd4294967296, 64'd1580030169, 64'd581260615, 64'd213833830, 64'd78665070,
    64'd28939262, 64'd10646160, 64'd3916503, 64'd1440801, 64'd530041, 64'd194991,
    64'd71733, 64'd26389, 64'd9708, 64'd3571, 64'd1314, 64'd483};
  int unsigned exp_part [17] = '{
    65536, 61565, 57835, 54331, 51040, 47947, 45042, 42313, 39750,
    37341, 35079, 32954, 30957, 29081, 27319, 25664, 24109};

  logic signed [15:0] dcos_mem [64];
  logic signed [15:0] dsin_mem [64];
  logic [15:0]        sig_mem [64];
  logic [23:0]        wnum_mem [64];
  logic [15:0]        dirf_mem [64];
  longint unsigned    gain_q;
  longint unsigned    ffilt_q;
  bit                 calm_q;
  longint unsigned    lin_gain_r;
  int unsigned        pm_r, cut_r, grav_r, dirs_r, freqs_r;

  source_t pending_sources [$];
  item_t   directed [$];
  int      errors = 0;
  bit      quiet = 1'b0;

  linear_wind_input_spectrum u_top (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("** linear_wind_input_spectrum: FAILED **");
    $finish;
  end

  function automatic longint unsigned mul_sat_shr(longint unsigned a, longint unsigned b,
                                                  int s);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> s;
    if (p[127:64] != 0) return '1;
    return p[63:0];
  endfunction

  function automatic int unsigned count_clamp(int unsigned v);
    if (v < 1) return 1;
    return (v > 64) ? 64 : v;
  endfunction

  function automatic void wind_cs(input logic [15:0] ang, output int c, output int s);
    int z, x, y, nx;
    bit neg;
    z = ang;
    x = 39797;
    y = 0;
    neg = 1'b0;
    if (z >= 32768) z -= 65536;
    if (z > 16384) begin
      z -= 32768;
      neg = 1'b1;
    end else if (z < -16384) begin
      z += 32768;
      neg = 1'b1;
    end
    for (int i = 0; i < 14; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ang_step[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ang_step[i];
      end
      x = nx;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic longint unsigned exp_weight(longint unsigned x);
    int unsigned n, fr, j, t, ef;
    if (x > (64'd16 << 16)) x = 64'd16 << 16;
    n = 32'(x >> 16);
    fr = 32'(x & 64'hFFFF);
    if (n >= 16) return exp_whole[16];
    j = fr >> 12;
    t = fr & 32'hFFF;
    ef = exp_part[j] - (((exp_part[j] - exp_part[j + 1]) * t) >> 12);
    return (exp_whole[n] * ef) >> 16;
  endfunction

  function automatic void apply_set_point(item_t it);
    int              cu, su;
    longint          p;
    longint unsigned pq, p2, u2, ff1, ff2, smax, top, fhigh;
    int unsigned     nf;
    nf = count_clamp(freqs_r);
    wind_cs(it.ang, cu, su);
    for (int i = 0; i < 64; i++) begin
      p = longint'(dcos_mem[i]) * cu + longint'(dsin_mem[i]) * su;
      pq = (p <= 0) ? 0 : (p >> 16);
      if (pq > 16384) pq = 16384;
      p2 = (pq * pq) >> 14;
      dirf_mem[i] = 16'((p2 * p2) >> 13);
    end
    u2 = longint'(it.u) * it.u;
    gain_q = mul_sat_shr(lin_gain_r, u2 * u2, 52);
    if (gain_q > MAX48) gain_q = MAX48;
    if (it.u == 0) ff1 = FF_MAX;
    else begin
      ff1 = (longint'(pm_r) * grav_r) / (64'd14 * it.u);
      if (ff1 > FF_MAX) ff1 = FF_MAX;
    end
    smax = sig_mem[nf - 1];
    fhigh = it.fc;
    ff2 = (longint'(cut_r) * ((smax < fhigh) ? smax : fhigh)) >> 12;
    if (ff2 > FF_MAX) ff2 = FF_MAX;
    top = (ff1 > ff2) ? ff1 : ff2;
    if (top > 2 * smax) top = 2 * smax;
    ffilt_q = top;
    calm_q = (it.u == 0);
  endfunction

  function automatic void predict_row(item_t it);
    int unsigned     nd, nf;
    longint unsigned sig, q, q2, w, k, t, v;
    source_t         e;
    nd = count_clamp(dirs_r);
    nf = count_clamp(freqs_r);
    if (it.idx >= nf) return;
    t = 0;
    sig = sig_mem[it.idx];
    if (!calm_q && ffilt_q != 0 && 2 * sig >= ffilt_q) begin
      q = (ffilt_q << 16) / sig;
      q2 = (q * q) >> 16;
      w = exp_weight((q2 * q2) >> 16);
      k = (wnum_mem[it.idx] != 0) ? wnum_mem[it.idx] : 1;
      t = mul_sat_shr((gain_q << 16) / k, w, 24);
    end
    for (int i = 0; i < nd; i++) begin
      v = mul_sat_shr(t, dirf_mem[i], 15);
      e.val = 48'((v > MAX48) ? MAX48 : v);
      if (it.pinned) e.val = it.pin_val;
      e.dir = 6'(i);
      e.frq = it.idx;
      e.is_last = (i == nd - 1);
      pending_sources.push_back(e);
    end
  endfunction

  function automatic void apply_item(item_t it);
    case (it.cmd)
      CMD_LOAD_DIR: begin
        dcos_mem[it.idx] = it.dc;
        dsin_mem[it.idx] = it.ds;
      end
      CMD_LOAD_FRQ: begin
        sig_mem[it.idx] = it.fr;
        wnum_mem[it.idx] = it.wn;
      end
      CMD_SET_POINT: apply_set_point(it);
      default: predict_row(it);
    endcase
  endfunction

  function automatic item_t mk(cmd_e cmd, logic [5:0] idx, logic signed [15:0] dc,
                               logic signed [15:0] ds, logic [15:0] fr, logic [23:0] wn,
                               logic [15:0] u, logic [15:0] ang, logic [15:0] fc,
                               bit pinned = 0, logic [47:0] pin_val = 0);
    item_t it;
    it.cmd = cmd;
    it.idx = idx;
    it.dc = dc;
    it.ds = ds;
    it.fr = fr;
    it.wn = wn;
    it.u = u;
    it.ang = ang;
    it.fc = fc;
    it.pinned = pinned;
    it.pin_val = pin_val;
    return it;
  endfunction

  function automatic item_t rand_item(cmd_e cmd);
    item_t it;
    it = mk(cmd, $urandom_range(0, 63), $urandom_range(0, 32768) - 16384,
            $urandom_range(0, 32768) - 16384, $urandom_range(200, 40000),
            $urandom_range(1, 24'hFFFFFF), $urandom_range(800, 6000), $urandom,
            $urandom_range(0, 65535));
    if ($urandom_range(0, 9) == 0) begin
      it.dc = $urandom;
      it.ds = $urandom;
      it.fr = $urandom;
      it.wn = $urandom;
      it.u = $urandom;
    end
    if ($urandom_range(0, 15) == 0) it.u = 0;
    return it;
  endfunction

  task automatic send(item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_command_i <= it.cmd;
    in_bin_index_i <= it.idx;
    in_dir_cos_i <= it.dc;
    in_dir_sin_i <= it.ds;
    in_rad_freq_i <= it.fr;
    in_wavenumber_i <= it.wn;
    in_friction_velocity_i <= it.u;
    in_wind_angle_i <= it.ang;
    in_cutoff_freq_i <= it.fc;
    do @(posedge clk_i); while (in_stall_o);
    apply_item(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_sources.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] index, logic [39:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    case (index)
      CFG_LIN_GAIN: lin_gain_r = data;
      CFG_PM:       pm_r = data[15:0];
      CFG_CUTOFF:   cut_r = data[15:0];
      CFG_GRAVITY:  grav_r = data[15:0];
      CFG_DIRS:     dirs_r = data[6:0];
      CFG_FREQS:    freqs_r = data[6:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_traffic(int n);
    item_t it;
    int    pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        send(rand_item(CMD_SET_POINT));
        repeat ($urandom_range(1, 3)) begin
          it = rand_item(CMD_EMIT);
          it.idx = $urandom_range(0, count_clamp(freqs_r) - 1);
          if ($urandom_range(0, 7) == 0) it.idx = $urandom_range(0, 63);
          send(it);
          k++;
        end
      end else if (pick < 8) begin
        send(rand_item(CMD_EMIT));
      end else begin
        send(rand_item($urandom_range(0, 1) ? CMD_LOAD_DIR : CMD_LOAD_FRQ));
      end
      if ($urandom_range(0, 19) == 0) quiet = !quiet;
    end
  endtask

  always begin
    int hold;
    hold = quiet ? 0 : $urandom_range(0, 12);
    repeat (hold) begin
      @(negedge clk_i);
      out_stall_i <= 1'b1;
    end
    @(negedge clk_i);
    out_stall_i <= 1'b0;
    do @(posedge clk_i); while (!out_valid_o);
  end

  always @(posedge clk_i) begin
    source_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_sources.size() == 0) begin
        $error("unexpected result: dir %0d freq %0d", out_dir_index_o, out_freq_index_o);
        errors++;
      end else begin
        e = pending_sources.pop_front();
        if (out_source_value_o !== e.val) begin
          $error("source_value: expected %0d, got %0d", e.val, out_source_value_o);
          errors++;
        end
        if (out_dir_index_o !== e.dir) begin
          $error("dir_index: expected %0d, got %0d", e.dir, out_dir_index_o);
          errors++;
        end
        if (out_freq_index_o !== e.frq) begin
          $error("freq_index: expected %0d, got %0d", e.frq, out_freq_index_o);
          errors++;
        end
        if (out_last_o !== e.is_last) begin
          $error("last: expected %0d, got %0d", e.is_last, out_last_o);
          errors++;
        end
      end
    end
  end

  initial begin
    gain_q = 0;
    ffilt_q = 0;
    calm_q = 1'b1;
    lin_gain_r = LIN_GAIN_RST;
    pm_r = PM_RST;
    cut_r = CUT_RST;
    grav_r = GRAV_RST;
    dirs_r = DIRS_RST;
    freqs_r = FREQS_RST;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 64; i++) begin
      send(mk(CMD_LOAD_DIR, i, $urandom_range(0, 32768) - 16384,
              $urandom_range(0, 32768) - 16384, 0, 0, 0, 0, 0));
      send(mk(CMD_LOAD_FRQ, i, 0, 0, 700 + i * 550 + $urandom_range(0, 300),
              $urandom_range(4000, 2000000), 0, 0, 0));
    end

    directed.push_back(mk(CMD_SET_POINT, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF));
    directed.push_back(mk(CMD_EMIT, 0, 0, 0, 0, 0, 0, 0, 0, 1, 48'd0));
    directed.push_back(mk(CMD_EMIT, 24, 0, 0, 0, 0, 0, 0, 0, 1, 48'd0));
    directed.push_back(mk(CMD_EMIT, 25, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(CMD_EMIT, 63, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(CMD_SET_POINT, 0, 0, 0, 0, 0, 16'hFFFF, 0, 0));
    directed.push_back(mk(CMD_EMIT, 12, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(CMD_SET_POINT, 0, 0, 0, 0, 0, 2458, 16384, 16'hFFFF));
    directed.push_back(mk(CMD_EMIT, 20, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(CMD_SET_POINT, 0, 0, 0, 0, 0, 1, 32768, 20000));
    directed.push_back(mk(CMD_EMIT, 3, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(CMD_SET_POINT, 0, 0, 0, 0, 0, 3000, 49152, 8000));
    directed.push_back(mk(CMD_SET_POINT, 0, 0, 0, 0, 0, 3000, 16385, 8000));
    directed.push_back(mk(CMD_SET_POINT, 0, 0, 0, 0, 0, 3000, 49151, 8000));
    directed.push_back(mk(CMD_EMIT, 24, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(CMD_LOAD_DIR, 63, -16384, 16384, 0, 0, 0, 0, 0));
    directed.push_back(mk(CMD_LOAD_DIR, 0, 16384, -16384, 0, 0, 0, 0, 0));
    directed.push_back(mk(CMD_LOAD_FRQ, 1, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(CMD_LOAD_FRQ, 2, 0, 0, 16'hFFFF, 24'hFFFFFF, 0, 0, 0));
    directed.push_back(mk(CMD_LOAD_FRQ, 5, 0, 0, 9000, 24'd0, 0, 0, 0));
    directed.push_back(mk(CMD_SET_POINT, 0, 0, 0, 0, 0, 2500, 16'hFFFF, 16'hFFFF));
    directed.push_back(mk(CMD_EMIT, 1, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(CMD_EMIT, 2, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(CMD_EMIT, 5, 0, 0, 0, 0, 0, 0, 0));
    foreach (directed[i]) send(directed[i]);
    random_traffic(15);
    drain();

    write_reg(CFG_LIN_GAIN, 40'hFF_FFFF_FFFF);
    write_reg(CFG_PM, 40'hFFFF);
    write_reg(CFG_CUTOFF, 40'hFFFF);
    write_reg(CFG_GRAVITY, 40'hFFFF);
    write_reg(CFG_DIRS, 40'd64);
    write_reg(CFG_FREQS, 40'd64);
    write_reg(CFG_SPARE_LO, 40'hAA_5555_AAAA);
    random_traffic(15);
    drain();

    write_reg(CFG_LIN_GAIN, 40'd0);
    write_reg(CFG_PM, 40'd0);
    write_reg(CFG_CUTOFF, 40'd0);
    write_reg(CFG_GRAVITY, 40'd0);
    write_reg(CFG_DIRS, 40'd0);
    write_reg(CFG_FREQS, 40'd1);
    write_reg(CFG_SPARE_HI, 40'h55_AAAA_5555);
    random_traffic(10);
    drain();

    write_reg(CFG_LIN_GAIN, 40'd50_000_000);
    write_reg(CFG_DIRS, 40'd127);
    write_reg(CFG_FREQS, 40'd0);
    write_reg(CFG_PM, 40'd4096);
    write_reg(CFG_CUTOFF, 40'd6000);
    write_reg(CFG_GRAVITY, 40'd20091);
    random_traffic(10);
    drain();

    write_reg(CFG_LIN_GAIN, 40'($urandom));
    write_reg(CFG_PM, 40'($urandom_range(0, 65535)));
    write_reg(CFG_CUTOFF, 40'($urandom_range(4096, 16384)));
    write_reg(CFG_GRAVITY, 40'($urandom_range(0, 65535)));
    write_reg(CFG_DIRS, 40'($urandom_range(1, 64)));
    write_reg(CFG_FREQS, 40'd127);
    random_traffic(15);
    drain();

    if (errors == 0) $display("** linear_wind_input_spectrum: PASSED **");
    else $display("** linear_wind_input_spectrum: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lwis_pkg.sv
rtl/lwis_div.sv
rtl/linear_wind_input_spectrum.sv
bench/tb.sv
